/* hdl/lkv_pkg.sv */
// lkv_pkg: shared types and constants for the lru key/value cache
// no dependencies; used by every module under hdl
package lkv_pkg;

   localparam int ENTRIES_DEFAULT = 16;

   localparam int          CAP_WIDTH  = 5;
   localparam logic [4:0]  CAP_RESET  = 5'd16;
   localparam logic [31:0] MISS_VALUE = 32'hFFFF_FFFF;

   typedef enum logic {
      CMD_GET = 1'b0,
      CMD_PUT = 1'b1
   } command_type;

   typedef struct packed {
      command_type        command;
      logic signed [31:0] key;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic               hit;
      logic signed [31:0] read_value;
   } rsp_type;

   // what the tag compare hands back to the update logic
   typedef struct packed {
      logic               hit;
      logic signed [31:0] value;
   } lookup_type;

endpackage

/* hdl/lru_key_value_cache.sv */
// lru_key_value_cache: fully associative key/value cache with lru replacement
// depends on lkv_pkg, lkv_lookup, lkv_replace
// a request waits in the request register, longer while the response side stalls, and its
//   response is registered in the response register; the compare/update pass is combinational
// throughput: one request per cycle while the response side does not stall
// reset: all entries invalid, occupancy zero, capacity 16
module lru_key_value_cache #(
   parameter int ENTRIES = lkv_pkg::ENTRIES_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          req_valid,
   output logic                          req_stall,
   input  lkv_pkg::req_type              req_payload,
   // response channel
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output lkv_pkg::rsp_type              rsp_payload,
   // capacity register
   input  logic                          csr_write,
   input  logic [lkv_pkg::CAP_WIDTH-1:0] csr_wdata
);

   localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int OW = $clog2(ENTRIES + 1);

   // request and response stage registers
   logic                  req_valid_ff, req_valid_in;
   lkv_pkg::req_type      req_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   lkv_pkg::rsp_type      rsp_ff, rsp_in;

   // entry storage
   logic [ENTRIES-1:0][31:0]   key_ff,   key_in;
   logic [ENTRIES-1:0][31:0]   value_ff, value_in;
   logic [ENTRIES-1:0][AW-1:0] age_ff,   age_in;
   logic [ENTRIES-1:0]         valid_ff, valid_in;
   logic [OW-1:0]              occ_ff,   occ_in;
   logic [lkv_pkg::CAP_WIDTH-1:0] cap_ff, cap_in;

   // lookup and replacement results
   logic [ENTRIES-1:0]    match;
   logic [AW-1:0]         hit_age;
   lkv_pkg::lookup_type   lookup;
   logic                  evict;
   logic [ENTRIES-1:0]    valid_after;
   logic [ENTRIES-1:0]    free_slot;

   logic advance;
   logic accept;
   logic is_put;

   // the held request moves on when the response register is free or being drained
   assign advance   = req_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = req_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;
   assign is_put    = (req_ff.command == lkv_pkg::CMD_PUT);

   lkv_lookup #(
      .ENTRIES (ENTRIES),
      .AW      (AW)
   ) u_lookup (
      .entry_key   (key_ff),
      .entry_value (value_ff),
      .entry_age   (age_ff),
      .entry_valid (valid_ff),
      .key         (req_ff.key),
      .match       (match),
      .hit_age     (hit_age),
      .result      (lookup)
   );

   lkv_replace #(
      .ENTRIES (ENTRIES),
      .AW      (AW),
      .OW      (OW)
   ) u_replace (
      .entry_age   (age_ff),
      .entry_valid (valid_ff),
      .occupancy   (occ_ff),
      .capacity    (cap_ff),
      .evict       (evict),
      .valid_after (valid_after),
      .free_slot   (free_slot)
   );

   // handshake bookkeeping
   always_comb begin
      if (accept) begin
         req_valid_in = 1'b1;
      end else if (advance) begin
         req_valid_in = 1'b0;
      end else begin
         req_valid_in = req_valid_ff;
      end

      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end

      cap_in = csr_write ? csr_wdata : cap_ff;
   end

   // response value
   always_comb begin
      rsp_in.hit = lookup.hit;
      if (is_put) begin
         rsp_in.read_value = req_ff.value;
      end else if (lookup.hit) begin
         rsp_in.read_value = lookup.value;
      end else begin
         rsp_in.read_value = lkv_pkg::MISS_VALUE;
      end
   end

   // entry update for the request leaving the request register
   always_comb begin
      key_in   = key_ff;
      value_in = value_ff;
      age_in   = age_ff;
      valid_in = valid_ff;
      occ_in   = occ_ff;
      if (advance) begin
         if (lookup.hit) begin
            // touch: younger entries age by one, the hit becomes most recent
            for (int i = 0; i < ENTRIES; i++) begin
               if (match[i]) begin
                  age_in[i] = '0;
                  if (is_put) begin
                     value_in[i] = req_ff.value;
                  end
               end else if (valid_ff[i] && (age_ff[i] < hit_age)) begin
                  age_in[i] = age_ff[i] + AW'(1);
               end
            end
         end else if (is_put) begin
            // insert after an optional eviction; every surviving entry ages by one
            for (int i = 0; i < ENTRIES; i++) begin
               if (valid_after[i]) begin
                  age_in[i] = age_ff[i] + AW'(1);
               end else begin
                  age_in[i] = '0;
               end
               if (free_slot[i]) begin
                  key_in[i]   = req_ff.key;
                  value_in[i] = req_ff.value;
               end
            end
            valid_in = valid_after | free_slot;
            occ_in   = evict ? occ_ff : occ_ff + OW'(1);
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         valid_ff     <= '0;
         age_ff       <= '0;
         occ_ff       <= '0;
         cap_ff       <= lkv_pkg::CAP_RESET;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         valid_ff     <= valid_in;
         age_ff       <= age_in;
         occ_ff       <= occ_in;
         cap_ff       <= cap_in;
      end
   end

   // payload and entry contents, no reset needed
   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_payload;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
      key_ff   <= key_in;
      value_ff <= value_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

/* hdl/lkv_lookup.sv */
// lkv_lookup: parallel key compare over all entries, selects value and age of the hit
// depends on lkv_pkg
module lkv_lookup #(
   parameter int ENTRIES = lkv_pkg::ENTRIES_DEFAULT,
   parameter int AW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
   input  logic [ENTRIES-1:0][31:0]   entry_key,
   input  logic [ENTRIES-1:0][31:0]   entry_value,
   input  logic [ENTRIES-1:0][AW-1:0] entry_age,
   input  logic [ENTRIES-1:0]         entry_valid,
   input  logic signed [31:0]         key,
   output logic [ENTRIES-1:0]         match,
   output logic [AW-1:0]              hit_age,
   output lkv_pkg::lookup_type        result
);

   logic [31:0]   value_or;
   logic [AW-1:0] age_or;

   // keys are unique among valid entries, so at most one match
   always_comb begin
      value_or = '0;
      age_or   = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         match[i] = entry_valid[i] && (entry_key[i] == key);
         if (match[i]) begin
            value_or = value_or | entry_value[i];
            age_or   = age_or | entry_age[i];
         end
      end
   end

   assign hit_age      = age_or;
   assign result.hit   = |match;
   assign result.value = value_or;

endmodule

/* hdl/lkv_replace.sv */
// lkv_replace: eviction decision, victim pick and free slot pick for an insert
// depends on lkv_pkg
module lkv_replace #(
   parameter int ENTRIES = lkv_pkg::ENTRIES_DEFAULT,
   parameter int AW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
   parameter int OW      = $clog2(ENTRIES + 1)
) (
   input  logic [ENTRIES-1:0][AW-1:0]       entry_age,
   input  logic [ENTRIES-1:0]               entry_valid,
   input  logic [OW-1:0]                    occupancy,
   input  logic [lkv_pkg::CAP_WIDTH-1:0]    capacity,
   output logic                             evict,
   output logic [ENTRIES-1:0]               valid_after,
   output logic [ENTRIES-1:0]               free_slot
);

   localparam int CW = (OW > lkv_pkg::CAP_WIDTH) ? OW : lkv_pkg::CAP_WIDTH;

   logic [CW-1:0]      cap_ext;
   logic [CW-1:0]      cap_eff;
   logic [OW-1:0]      oldest_age;
   logic [ENTRIES-1:0] victim;

   // zero reads as one, anything above the entry count saturates
   always_comb begin
      cap_ext = CW'(capacity);
      if (cap_ext == '0) begin
         cap_eff = CW'(1);
      end else if (cap_ext > CW'(ENTRIES)) begin
         cap_eff = CW'(ENTRIES);
      end else begin
         cap_eff = cap_ext;
      end
   end

   assign evict = (CW'(occupancy) >= cap_eff);

   // ages of valid entries are a permutation of 0..occupancy-1
   assign oldest_age = occupancy - OW'(1);

   always_comb begin
      for (int i = 0; i < ENTRIES; i++) begin
         victim[i] = entry_valid[i] && (entry_age[i] == AW'(oldest_age));
      end
   end

   assign valid_after = evict ? (entry_valid & ~victim) : entry_valid;
   // lowest clear bit
   assign free_slot   = ~valid_after & (valid_after + ENTRIES'(1));

endmodule

/* dv/testbench.sv */
// testbench for lru_key_value_cache: shadow lru cache, directed and random requests
// depends on lkv_pkg and the lru_key_value_cache rtl
`timescale 1ns / 100ps

// shadow copy of the cache contents; predicts the response of every accepted request
class lru_shadow;
   localparam int SLOTS = lkv_pkg::ENTRIES_DEFAULT;

   logic signed [31:0] slot_key[SLOTS];
   logic signed [31:0] slot_value[SLOTS];
   bit                 slot_valid[SLOTS];
   logic [3:0]         slot_age[SLOTS];
   int                 fill;
   logic [4:0]         capacity;

   lkv_pkg::rsp_type   owed_responses[$];
   int                 errors;
   int                 gets;
   int                 puts;
   int                 get_hits;
   int                 evictions;
   int                 checked;

   function new();
      for (int i = 0; i < SLOTS; i++) begin
         slot_key[i]   = '0;
         slot_value[i] = '0;
         slot_valid[i] = 1'b0;
         slot_age[i]   = '0;
      end
      fill      = 0;
      capacity  = lkv_pkg::CAP_RESET;
      errors    = 0;
      gets      = 0;
      puts      = 0;
      get_hits  = 0;
      evictions = 0;
      checked   = 0;
   endfunction

   function void set_capacity(logic [4:0] cap);
      capacity = cap;
   endfunction

   // zero means one, anything past the slot count means all slots
   function int usable_slots();
      if (capacity == 0) return 1;
      if (capacity > SLOTS) return SLOTS;
      return capacity;
   endfunction

   function int slot_of(logic signed [31:0] k);
      for (int i = 0; i < SLOTS; i++)
         if (slot_valid[i] && slot_key[i] == k) return i;
      return -1;
   endfunction

   // move slot to the front; everything younger ages by one
   function void make_newest(int s);
      logic [3:0] a;
      a = slot_age[s];
      for (int i = 0; i < SLOTS; i++)
         if (slot_valid[i] && slot_age[i] < a) slot_age[i]++;
      slot_age[s] = '0;
   endfunction

   function void drop_oldest();
      int victim;
      victim = -1;
      for (int i = 0; i < SLOTS; i++)
         if (slot_valid[i] && (victim < 0 || slot_age[i] > slot_age[victim])) victim = i;
      if (victim >= 0) begin
         slot_valid[victim] = 1'b0;
         slot_age[victim]   = '0;
         if (fill > 0) fill--;
         evictions++;
      end
   endfunction

   function void note_request(lkv_pkg::req_type r);
      lkv_pkg::rsp_type want;
      int               s;
      int               slot;
      s = slot_of(r.key);
      if (r.command == lkv_pkg::CMD_GET) begin
         gets++;
         if (s >= 0) begin
            make_newest(s);
            want.hit        = 1'b1;
            want.read_value = slot_value[s];
            get_hits++;
         end else begin
            want.hit        = 1'b0;
            want.read_value = lkv_pkg::MISS_VALUE;
         end
      end else if (s >= 0) begin
         puts++;
         slot_value[s] = r.value;
         make_newest(s);
         want.hit        = 1'b1;
         want.read_value = r.value;
      end else begin
         puts++;
         // a shrunk capacity takes back one slot per new key
         if (fill >= usable_slots()) drop_oldest();
         slot = -1;
         for (int i = 0; i < SLOTS; i++)
            if (!slot_valid[i] && slot < 0) slot = i;
         if (slot < 0) begin
            drop_oldest();
            for (int i = 0; i < SLOTS; i++)
               if (!slot_valid[i] && slot < 0) slot = i;
         end
         if (slot >= 0) begin
            for (int i = 0; i < SLOTS; i++)
               if (slot_valid[i]) slot_age[i]++;
            slot_key[slot]   = r.key;
            slot_value[slot] = r.value;
            slot_valid[slot] = 1'b1;
            slot_age[slot]   = '0;
            fill++;
         end
         want.hit        = 1'b0;
         want.read_value = r.value;
      end
      owed_responses.insert(owed_responses.size(), want);
   endfunction

   function void check_response(lkv_pkg::rsp_type got);
      lkv_pkg::rsp_type want;
      if (owed_responses.size() == 0) begin
         $error("response with no request outstanding: hit %0d read_value %0d",
                got.hit, got.read_value);
         errors++;
         return;
      end
      want = owed_responses.pop_front();
      checked++;
      if (got.hit !== want.hit) begin
         $error("hit: expected %0d, actual %0d", want.hit, got.hit);
         errors++;
      end
      if (got.read_value !== want.read_value) begin
         $error("read_value: expected %0d, actual %0d", want.read_value, got.read_value);
         errors++;
      end
   endfunction
endclass

module testbench;

   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN_CYCLES = 4;

   // clock and synchronous reset
   logic clock = 1'b0;
   logic reset = 1'b1;

   // request side, driven at the falling edge
   logic             req_valid   = 1'b0;
   logic             req_stall;
   lkv_pkg::req_type req_payload = '0;

   // response side; stall driven at the falling edge
   logic             rsp_valid;
   logic             rsp_stall   = 1'b0;
   lkv_pkg::rsp_type rsp_payload;

   // capacity register port
   logic       csr_write = 1'b0;
   logic [4:0] csr_wdata = '0;

   // idling knobs, percent per cycle
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   // long response hold-off, counted down by the response-side process
   int hold_left      = 0;

   int cycle_count    = 0;
   int settings_run   = 0;

   lru_shadow shadow = new();

   lru_key_value_cache dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_write   (csr_write),
      .csr_wdata   (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // watchdog: a hung block ends the run here
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses still owed",
                  cycle_count, shadow.owed_responses.size());
         $display("testbench: done, errors");
         $finish;
      end
   end

   // response side stall: either a long hold-off or random stalls
   always begin
      @(negedge clock);
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   // every response taken at a rising edge is checked against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) shadow.check_response(rsp_payload);
   end

   function automatic lkv_pkg::req_type make_request(lkv_pkg::command_type cmd,
                                                     logic signed [31:0] k,
                                                     logic signed [31:0] v);
      lkv_pkg::req_type r;
      r.command = cmd;
      r.key     = k;
      r.value   = v;
      return r;
   endfunction

   // offer one request, with random idle cycles first; returns at the accepting edge
   task automatic send_request(input lkv_pkg::req_type r);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      shadow.note_request(r);
   endtask

   // stop offering and wait until every owed response is back
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (shadow.owed_responses.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [4:0] cap);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_wdata <= cap;
      @(negedge clock);
      csr_write <= 1'b0;
      shadow.set_capacity(cap);
      settings_run++;
   endtask

   // random traffic over a key pool a bit larger than the usable slots,
   // so hits, updates and evictions all happen often
   task automatic run_setting(input logic [4:0] cap, input int count,
                              input int send_pct, input int recv_pct, input bit long_hold);
      logic signed [31:0]   key_pool[$];
      logic signed [31:0]   k;
      int                   usable;
      int                   pick;
      lkv_pkg::command_type cmd;
      drain();
      write_capacity(cap);
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
      usable = (cap == 0) ? 1 : (cap > 16) ? 16 : cap;
      repeat ($urandom_range(usable + 1, 2 * usable + 2))
         key_pool.insert(key_pool.size(), $urandom);
      // response side holds off while requests keep coming, so the block backs up
      if (long_hold) hold_left = 90;
      repeat (count) begin
         pick = $urandom_range(99);
         if (pick < 85)
            k = key_pool[$urandom_range(key_pool.size() - 1)];
         else if (pick < 95)
            k = $urandom;
         else
            case ($urandom_range(3))
               0: k = 32'sh8000_0000;
               1: k = 32'sh7FFF_FFFF;
               2: k = 32'sh0000_0000;
               default: k = -32'sd1;
            endcase
         cmd = ($urandom_range(99) < 45) ? lkv_pkg::CMD_PUT : lkv_pkg::CMD_GET;
         send_request(make_request(cmd, k, $urandom));
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed part at full capacity, sender 21% idle, receiver 45% stalled
      write_capacity(5'd16);
      send_idle_pct  = 21;
      recv_stall_pct = 45;
      // lookup in an empty cache
      send_request(make_request(lkv_pkg::CMD_GET, 32'sh0000_0000, 32'sh0000_0000));
      // key and value extremes
      send_request(make_request(lkv_pkg::CMD_PUT, 32'sh8000_0000, 32'sh7FFF_FFFF));
      send_request(make_request(lkv_pkg::CMD_PUT, 32'sh7FFF_FFFF, 32'sh8000_0000));
      send_request(make_request(lkv_pkg::CMD_PUT, 32'sh0000_0000, 32'sh0000_0000));
      send_request(make_request(lkv_pkg::CMD_PUT, -32'sd1, -32'sd1));
      send_request(make_request(lkv_pkg::CMD_PUT, 32'shAAAA_AAAA, 32'sh5555_5555));
      send_request(make_request(lkv_pkg::CMD_PUT, 32'sh5555_5555, 32'shAAAA_AAAA));
      send_request(make_request(lkv_pkg::CMD_GET, 32'sh8000_0000, 32'sh0000_0000));
      send_request(make_request(lkv_pkg::CMD_GET, 32'sh7FFF_FFFF, 32'sh0000_0000));
      send_request(make_request(lkv_pkg::CMD_GET, 32'sh0000_0000, 32'sh0000_0000));
      send_request(make_request(lkv_pkg::CMD_GET, -32'sd1, 32'sh0000_0000));
      send_request(make_request(lkv_pkg::CMD_GET, 32'shAAAA_AAAA, 32'sh0000_0000));
      send_request(make_request(lkv_pkg::CMD_GET, 32'sh5555_5555, 32'sh0000_0000));
      // value field on a lookup is ignored
      send_request(make_request(lkv_pkg::CMD_GET, 32'sh7FFF_FFFF, 32'sh1234_5678));
      // update of a present key, then read back
      send_request(make_request(lkv_pkg::CMD_PUT, 32'sh8000_0000, 32'sh0000_0001));
      send_request(make_request(lkv_pkg::CMD_GET, 32'sh8000_0000, 32'sh0000_0000));
      // misses on absent keys, including neighbors of stored ones
      send_request(make_request(lkv_pkg::CMD_GET, 32'sh8000_0001, 32'sh0000_0000));
      send_request(make_request(lkv_pkg::CMD_GET, 32'sh7FFF_FFFE, 32'sh0000_0000));
      send_request(make_request(lkv_pkg::CMD_GET, 32'sh0000_3039, -32'sd1));

      // above the slot count saturates; long response hold-off here
      run_setting(5'd31, 140, 21, 45, 1'b1);
      // capacity dropped below occupancy: one eviction per new key
      run_setting(5'd2, 120, 21, 45, 1'b0);
      // now the receiver idles less and the sender more
      run_setting(5'd0, 100, 45, 21, 1'b0);
      run_setting(5'd1, 100, 45, 21, 1'b0);
      run_setting(5'd16, 140, 45, 21, 1'b0);
      // back to back, no idling on either side
      run_setting(5'd5, 110, 0, 0, 1'b0);
      run_setting(5'd9, 110, 0, 0, 1'b0);

      drain();

      $display("summary: %0d gets (%0d hits), %0d puts, %0d evictions, %0d responses checked",
               shadow.gets, shadow.get_hits, shadow.puts, shadow.evictions, shadow.checked);
      $display("summary: %0d capacity settings, %0d cycles", settings_run, cycle_count);
      if (shadow.errors == 0 && shadow.owed_responses.size() == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

endmodule
